### src/crc_pkg.sv
package crc_pkg;

  // Volume geometry
  localparam int MAX_CLUSTERS = 65536;
  localparam int MAP_BYTES    = (MAX_CLUSTERS + 7) / 8;
  localparam int MAP_AW       = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

  // Field widths
  localparam int CLUS_W = 17;
  localparam int CNT_W  = 17;
  localparam int BIDX_W = 13;

  localparam logic [31:0] FIRST_HEAP = 32'd2;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_MARK  = 2'd1,
    OP_DIFF  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    FAULT_NONE      = 3'd0,
    FAULT_BAD_DIR   = 3'd1,
    FAULT_BAD_CHAIN = 3'd2,
    FAULT_LOST      = 3'd3,
    FAULT_UNSET     = 3'd4
  } fault_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_RUN_FILL,
    ST_DIFF_READ,
    ST_DIFF_SCAN,
    ST_SUMMARY
  } state_t;

endpackage

### src/crc_in_if.sv
interface crc_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  operation;
  logic [31:0]                 first_cluster;
  logic [crc_pkg::CLUS_W-1:0]  run_length;
  logic                        fault_kind;
  logic [crc_pkg::BIDX_W-1:0]  byte_index;
  logic [7:0]                  alloc_byte;

  modport source (
    output valid, operation, first_cluster, run_length, fault_kind, byte_index, alloc_byte,
    input  ready
  );
  modport sink (
    input  valid, operation, first_cluster, run_length, fault_kind, byte_index, alloc_byte,
    output ready
  );
endinterface

### src/crc_out_if.sv
interface crc_out_if;
  logic                       valid;
  logic                       ready;
  logic [2:0]                 fault;
  logic [31:0]                fault_cluster;
  logic                       last;
  logic [crc_pkg::CNT_W-1:0]  used_total;
  logic [crc_pkg::CNT_W-1:0]  lost_total;
  logic [crc_pkg::CNT_W-1:0]  mismatch_total;

  modport source (
    output valid, fault, fault_cluster, last, used_total, lost_total, mismatch_total,
    input  ready
  );
  modport sink (
    input  valid, fault, fault_cluster, last, used_total, lost_total, mismatch_total,
    output ready
  );
endinterface

### src/crc_ram.sv
// Simple dual-port RAM, one write and one registered read port
module crc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### src/cluster_reference_checker.sv
// Cluster reference checker. Keeps one visited bit per heap cluster (cluster c
// is bit c-2) in an 8192-byte on-chip map and compares it with allocation
// bitmap bytes. Every transaction ends with a summary result (last = 1) that
// carries the running used, lost and mismatch totals; fault results come first.
// After reset, and for every clear transaction, the map is swept one byte per
// cycle, during which no transaction is taken (configuration writes still are).
// A mark run marks its clusters in a cached map byte; each time it steps into a
// new map byte the old byte is written back while the new one is fetched, and
// the run then finishes or is refused before its summary. A diff byte reads its
// map byte, then gives one fault result per faulty cluster before its summary.
// Transactions are accepted in the idle state; a stalled result holds the block.
// cluster_count may only be written while the block is idle.
module cluster_reference_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_en,
  input  logic [crc_pkg::CLUS_W-1:0] cfg_write_data,
  crc_in_if.sink                     item,
  crc_out_if.source                  result
);

  localparam int AW = crc_pkg::MAP_AW;
  localparam int BW = crc_pkg::BIDX_W + 3;

  // Saturating counter update
  function automatic logic [crc_pkg::CNT_W-1:0] sat_add(
    input logic [crc_pkg::CNT_W-1:0] a,
    input logic [3:0]                b
  );
    logic [crc_pkg::CNT_W:0] s;
    s = {1'b0, a} + (crc_pkg::CNT_W + 1)'(b);
    return s[crc_pkg::CNT_W] ? {crc_pkg::CNT_W{1'b1}} : s[crc_pkg::CNT_W-1:0];
  endfunction

  crc_pkg::state_t state, state_next;

  logic [crc_pkg::CLUS_W-1:0] cluster_count;
  logic [crc_pkg::CLUS_W-1:0] eff_count;

  logic [crc_pkg::CNT_W-1:0] used_count, used_count_next;
  logic [crc_pkg::CNT_W-1:0] lost_count, lost_count_next;
  logic [crc_pkg::CNT_W-1:0] mis_count, mis_count_next;

  logic [AW-1:0] clr_addr, clr_addr_next;
  logic          clr_emit, clr_emit_next;

  logic [31:0]                run_c, run_c_next;
  logic [crc_pkg::CLUS_W-1:0] run_left, run_left_next;
  logic                       run_kind, run_kind_next;

  logic [AW-1:0] cache_addr, cache_addr_next;
  logic [7:0]    cache_data, cache_data_next;
  logic          cache_valid, cache_valid_next;
  logic          cache_dirty, cache_dirty_next;

  logic [BW-1:0] diff_base, diff_base_next;
  logic [7:0]    diff_byte, diff_byte_next;
  logic [7:0]    diff_pend, diff_pend_next;
  logic [7:0]    diff_lost, diff_lost_next;

  logic                      out_valid, out_valid_next;
  crc_pkg::fault_t           out_fault, out_fault_next;
  logic [31:0]               out_cluster, out_cluster_next;
  logic                      out_last, out_last_next;
  logic [crc_pkg::CNT_W-1:0] out_used, out_used_next;
  logic [crc_pkg::CNT_W-1:0] out_lost, out_lost_next;
  logic [crc_pkg::CNT_W-1:0] out_mis, out_mis_next;

  logic          mem_wr_en, mem_rd_en;
  logic [AW-1:0] mem_wr_addr, mem_rd_addr;
  logic [7:0]    mem_wr_data, mem_rd_data;

  logic out_free;

  logic [31:0] run_idx;
  logic [AW-1:0] run_byte;
  logic [2:0]  run_bit;
  logic        run_in_range, run_hit, run_seen;

  logic [7:0] diff_live, diff_masked, lost_bits, mis_bits;
  logic [3:0] diff_pop;
  logic [2:0] scan_sel;

  // Visited map storage
  crc_ram #(.WIDTH(8), .DEPTH(crc_pkg::MAP_BYTES)) u_map (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Configuration register and effective cluster count
  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count <= '0;
    end else if (cfg_write_en) begin
      cluster_count <= cfg_write_data;
    end
  end

  assign eff_count = (32'(cluster_count) > 32'(crc_pkg::MAX_CLUSTERS)) ?
                     crc_pkg::CLUS_W'(crc_pkg::MAX_CLUSTERS) : cluster_count;

  // Current run cluster against range and the cached map byte
  always_comb begin
    run_idx      = run_c - crc_pkg::FIRST_HEAP;
    run_byte     = run_idx[3 +: AW];
    run_bit      = run_idx[2:0];
    run_in_range = (run_c >= crc_pkg::FIRST_HEAP) && (run_idx < 32'(eff_count));
    run_hit      = cache_valid && (cache_addr == run_byte);
    run_seen     = cache_data[run_bit];
  end

  // Diff byte: tail mask, population and per-bit verdicts
  always_comb begin
    diff_pop = '0;
    for (int j = 0; j < 8; j++) begin
      diff_live[j] = (32'(diff_base) + 32'(j)) < 32'(eff_count);
    end
    diff_masked = diff_byte & diff_live;
    for (int j = 0; j < 8; j++) begin
      diff_pop = diff_pop + 4'(diff_masked[j]);
    end
    lost_bits = diff_masked & ~mem_rd_data;
    mis_bits  = ~diff_masked & mem_rd_data & diff_live;
  end

  // Lowest pending fault bit
  always_comb begin
    scan_sel = '0;
    for (int j = 7; j >= 0; j--) begin
      if (diff_pend[j]) begin
        scan_sel = 3'(j);
      end
    end
  end

  assign out_free = !out_valid || result.ready;

  // Next state, map access and result generation
  always_comb begin
    state_next       = state;
    used_count_next  = used_count;
    lost_count_next  = lost_count;
    mis_count_next   = mis_count;
    clr_addr_next    = clr_addr;
    clr_emit_next    = clr_emit;
    run_c_next       = run_c;
    run_left_next    = run_left;
    run_kind_next    = run_kind;
    cache_addr_next  = cache_addr;
    cache_data_next  = cache_data;
    cache_valid_next = cache_valid;
    cache_dirty_next = cache_dirty;
    diff_base_next   = diff_base;
    diff_byte_next   = diff_byte;
    diff_pend_next   = diff_pend;
    diff_lost_next   = diff_lost;
    out_valid_next   = out_valid && !result.ready;
    out_fault_next   = out_fault;
    out_cluster_next = out_cluster;
    out_last_next    = out_last;
    out_used_next    = out_used;
    out_lost_next    = out_lost;
    out_mis_next     = out_mis;
    mem_wr_en        = 1'b0;
    mem_wr_addr      = cache_addr;
    mem_wr_data      = cache_data;
    mem_rd_en        = 1'b0;
    mem_rd_addr      = cache_addr;
    item.ready       = 1'b0;

    case (state)
      // Map sweep, one byte per cycle
      crc_pkg::ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_addr;
        mem_wr_data = '0;
        if (clr_addr == AW'(crc_pkg::MAP_BYTES - 1)) begin
          clr_addr_next = '0;
          state_next    = clr_emit ? crc_pkg::ST_SUMMARY : crc_pkg::ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + AW'(1);
        end
      end

      crc_pkg::ST_IDLE: begin
        item.ready = 1'b1;
        if (item.valid) begin
          case (item.operation)
            crc_pkg::OP_CLEAR: begin
              used_count_next = '0;
              lost_count_next = '0;
              mis_count_next  = '0;
              clr_addr_next   = '0;
              clr_emit_next   = 1'b1;
              state_next      = crc_pkg::ST_CLEAR;
            end
            crc_pkg::OP_MARK: begin
              run_c_next    = item.first_cluster;
              run_left_next = (item.run_length > eff_count) ? eff_count : item.run_length;
              run_kind_next = item.fault_kind;
              state_next    = crc_pkg::ST_RUN;
            end
            crc_pkg::OP_DIFF: begin
              diff_base_next = {item.byte_index, 3'b000};
              diff_byte_next = item.alloc_byte;
              mem_rd_en      = 1'b1;
              mem_rd_addr    = AW'(item.byte_index);
              state_next     = crc_pkg::ST_DIFF_READ;
            end
            default: begin
              state_next = crc_pkg::ST_SUMMARY;
            end
          endcase
        end
      end

      // One cluster per cycle while the run stays in the cached byte
      crc_pkg::ST_RUN: begin
        if (run_left == '0) begin
          mem_wr_en        = cache_dirty;
          cache_valid_next = 1'b0;
          cache_dirty_next = 1'b0;
          state_next       = crc_pkg::ST_SUMMARY;
        end else if (!run_in_range || (run_hit && run_seen)) begin
          if (out_free) begin
            out_valid_next   = 1'b1;
            out_fault_next   = run_kind ? crc_pkg::FAULT_BAD_CHAIN : crc_pkg::FAULT_BAD_DIR;
            out_cluster_next = run_c;
            out_last_next    = 1'b0;
            out_used_next    = used_count;
            out_lost_next    = lost_count;
            out_mis_next     = mis_count;
            mem_wr_en        = cache_dirty;
            cache_valid_next = 1'b0;
            cache_dirty_next = 1'b0;
            state_next       = crc_pkg::ST_SUMMARY;
          end
        end else if (run_hit) begin
          cache_data_next  = cache_data | (8'd1 << run_bit);
          cache_dirty_next = 1'b1;
          run_c_next       = run_c + 32'd1;
          run_left_next    = run_left - crc_pkg::CLUS_W'(1);
        end else begin
          // write back the old byte while fetching the new one
          mem_wr_en        = cache_dirty;
          mem_rd_en        = 1'b1;
          mem_rd_addr      = run_byte;
          cache_addr_next  = run_byte;
          cache_valid_next = 1'b0;
          cache_dirty_next = 1'b0;
          state_next       = crc_pkg::ST_RUN_FILL;
        end
      end

      crc_pkg::ST_RUN_FILL: begin
        cache_data_next  = mem_rd_data;
        cache_valid_next = 1'b1;
        state_next       = crc_pkg::ST_RUN;
      end

      crc_pkg::ST_DIFF_READ: begin
        used_count_next = sat_add(used_count, diff_pop);
        diff_pend_next  = lost_bits | mis_bits;
        diff_lost_next  = lost_bits;
        state_next      = crc_pkg::ST_DIFF_SCAN;
      end

      // One fault result per cycle while the output takes it, lowest cluster first
      crc_pkg::ST_DIFF_SCAN: begin
        if (diff_pend == '0) begin
          state_next = crc_pkg::ST_SUMMARY;
        end else if (out_free) begin
          if (diff_lost[scan_sel]) begin
            lost_count_next = sat_add(lost_count, 4'd1);
            out_fault_next  = crc_pkg::FAULT_LOST;
          end else begin
            mis_count_next  = sat_add(mis_count, 4'd1);
            out_fault_next  = crc_pkg::FAULT_UNSET;
          end
          out_valid_next   = 1'b1;
          out_cluster_next = 32'(diff_base) + 32'(scan_sel) + crc_pkg::FIRST_HEAP;
          out_last_next    = 1'b0;
          out_used_next    = used_count;
          out_lost_next    = lost_count_next;
          out_mis_next     = mis_count_next;
          diff_pend_next   = diff_pend & ~(8'd1 << scan_sel);
        end
      end

      crc_pkg::ST_SUMMARY: begin
        if (out_free) begin
          out_valid_next   = 1'b1;
          out_fault_next   = crc_pkg::FAULT_NONE;
          out_cluster_next = '0;
          out_last_next    = 1'b1;
          out_used_next    = used_count;
          out_lost_next    = lost_count;
          out_mis_next     = mis_count;
          state_next       = crc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = crc_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= crc_pkg::ST_CLEAR;
      clr_addr    <= '0;
      clr_emit    <= 1'b0;
      used_count  <= '0;
      lost_count  <= '0;
      mis_count   <= '0;
      cache_valid <= 1'b0;
      cache_dirty <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      clr_addr    <= clr_addr_next;
      clr_emit    <= clr_emit_next;
      used_count  <= used_count_next;
      lost_count  <= lost_count_next;
      mis_count   <= mis_count_next;
      cache_valid <= cache_valid_next;
      cache_dirty <= cache_dirty_next;
      out_valid   <= out_valid_next;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    run_c       <= run_c_next;
    run_left    <= run_left_next;
    run_kind    <= run_kind_next;
    cache_addr  <= cache_addr_next;
    cache_data  <= cache_data_next;
    diff_base   <= diff_base_next;
    diff_byte   <= diff_byte_next;
    diff_pend   <= diff_pend_next;
    diff_lost   <= diff_lost_next;
    out_fault   <= out_fault_next;
    out_cluster <= out_cluster_next;
    out_last    <= out_last_next;
    out_used    <= out_used_next;
    out_lost    <= out_lost_next;
    out_mis     <= out_mis_next;
  end

  assign result.valid          = out_valid;
  assign result.fault          = out_fault;
  assign result.fault_cluster  = out_cluster;
  assign result.last           = out_last;
  assign result.used_total     = out_used;
  assign result.lost_total     = out_lost;
  assign result.mismatch_total = out_mis;

  // Map sweep holds off transactions straight after reset
  a_sweep_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !item.ready)
    else $error("transaction taken before the map sweep finished");

  // Cached byte is always written back before a new transaction
  a_cache_flushed: assert property (@(posedge clk) disable iff (rst)
    item.ready |-> !cache_valid && !cache_dirty)
    else $error("cached map byte still live while idle");

  // Write-back only ever comes from a live cache entry
  a_writeback_live: assert property (@(posedge clk) disable iff (rst)
    (mem_wr_en && state != crc_pkg::ST_CLEAR) |-> cache_valid)
    else $error("map write-back without a valid cached byte");

  // Fetch and write-back never collide on one map byte
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
    else $error("map read and write to the same byte in one cycle");

  // Each diff fault result retires exactly one pending bit
  a_scan_progress: assert property (@(posedge clk) disable iff (rst)
    (state == crc_pkg::ST_DIFF_SCAN && out_free && diff_pend != '0) |=>
      ($countones(diff_pend) + 1 == $countones($past(diff_pend))))
    else $error("diff scan did not retire one pending cluster");

endmodule

### test/cluster_reference_checker_tb.sv
module cluster_reference_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  OP_UNDEFINED = 2'd3;
  localparam int unsigned TALLY_MAX    = (1 << crc_pkg::CNT_W) - 1;
  localparam int unsigned LENGTH_MAX   = (1 << crc_pkg::CLUS_W) - 1;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int          VIS_AW       = $clog2(crc_pkg::MAX_CLUSTERS);

  typedef struct {
    logic [1:0]                 operation;
    logic [31:0]                first_cluster;
    logic [crc_pkg::CLUS_W-1:0] run_length;
    logic                       fault_kind;
    logic [crc_pkg::BIDX_W-1:0] byte_index;
    logic [7:0]                 alloc_byte;
  } txn_t;

  typedef struct {
    crc_pkg::fault_t           fault;
    logic [31:0]               cluster;
    logic                      last;
    logic [crc_pkg::CNT_W-1:0] used;
    logic [crc_pkg::CNT_W-1:0] lost;
    logic [crc_pkg::CNT_W-1:0] unset;
  } outcome_t;

  typedef enum int unsigned {
    PACE_OPEN,
    PACE_COIN,
    PACE_SPARSE,
    PACE_RHYTHM
  } pace_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_write_en;
  logic [crc_pkg::CLUS_W-1:0] cfg_write_data;

  crc_in_if  item_bus ();
  crc_out_if result_bus ();

  cluster_reference_checker i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .item           (item_bus),
    .result         (result_bus)
  );

  // Predicted volume state
  bit [crc_pkg::MAX_CLUSTERS-1:0] visited_bits;
  logic [crc_pkg::CNT_W-1:0]      used_tally;
  logic [crc_pkg::CNT_W-1:0]      lost_tally;
  logic [crc_pkg::CNT_W-1:0]      mismatch_tally;
  logic [crc_pkg::CLUS_W-1:0]     cluster_count_cfg;
  outcome_t                       awaited_results [$];

  // Run bookkeeping
  int unsigned mismatches;
  int unsigned txns_sent;
  int unsigned results_seen;
  int unsigned fault_hits [5];
  int unsigned burst_left;
  int unsigned holdoff_left;
  bit          flood;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic int unsigned volume_span();
    return (cluster_count_cfg > crc_pkg::MAX_CLUSTERS) ? crc_pkg::MAX_CLUSTERS :
                                                         32'(cluster_count_cfg);
  endfunction

  function automatic logic [crc_pkg::CNT_W-1:0] tally_add(
    input logic [crc_pkg::CNT_W-1:0] a,
    input int unsigned               inc
  );
    int unsigned s;
    s = 32'(a) + inc;
    return (s > TALLY_MAX) ? crc_pkg::CNT_W'(TALLY_MAX) : s[crc_pkg::CNT_W-1:0];
  endfunction

  function automatic void push_outcome(input crc_pkg::fault_t f, input logic [31:0] c,
                                       input logic l);
    outcome_t o;
    o.fault   = f;
    o.cluster = c;
    o.last    = l;
    o.used    = used_tally;
    o.lost    = lost_tally;
    o.unset   = mismatch_tally;
    awaited_results.push_back(o);
  endfunction

  // Marks clusters until the clamped length runs out or one is refused
  function automatic void predict_mark_run(input txn_t t);
    int unsigned span;
    int unsigned n;
    int unsigned i;
    logic [31:0] c;
    logic [31:0] idx;
    span = volume_span();
    n = 32'(t.run_length);
    if (n > span) n = span;
    for (i = 0; i < n; i++) begin
      c   = t.first_cluster + i;   // wraps at 2^32
      idx = c - crc_pkg::FIRST_HEAP;
      if (c < crc_pkg::FIRST_HEAP || idx >= span || visited_bits[VIS_AW'(idx)]) begin
        push_outcome(t.fault_kind ? crc_pkg::FAULT_BAD_CHAIN : crc_pkg::FAULT_BAD_DIR,
                     c, 1'b0);
        return;
      end
      visited_bits[VIS_AW'(idx)] = 1'b1;
    end
  endfunction

  // Tail bits past the volume are dropped before counting and comparing
  function automatic void predict_diff_byte(input txn_t t);
    int unsigned span;
    int unsigned base;
    int unsigned pop;
    int unsigned j;
    logic [7:0]  live;
    span = volume_span();
    base = 32'({t.byte_index, 3'b000});
    live = '0;
    pop  = 0;
    for (j = 0; j < 8; j++) begin
      if (base + j < span && t.alloc_byte[j]) begin
        live[j] = 1'b1;
        pop++;
      end
    end
    used_tally = tally_add(used_tally, pop);
    for (j = 0; j < 8 && base + j < span; j++) begin
      if (live[j] && !visited_bits[VIS_AW'(base + j)]) begin
        lost_tally = tally_add(lost_tally, 1);
        push_outcome(crc_pkg::FAULT_LOST, base + j + crc_pkg::FIRST_HEAP, 1'b0);
      end else if (!live[j] && visited_bits[VIS_AW'(base + j)]) begin
        mismatch_tally = tally_add(mismatch_tally, 1);
        push_outcome(crc_pkg::FAULT_UNSET, base + j + crc_pkg::FIRST_HEAP, 1'b0);
      end
    end
  endfunction

  function automatic void predict_transaction(input txn_t t);
    case (t.operation)
      crc_pkg::OP_CLEAR: begin
        visited_bits   = '0;
        used_tally     = '0;
        lost_tally     = '0;
        mismatch_tally = '0;
      end
      crc_pkg::OP_MARK: predict_mark_run(t);
      crc_pkg::OP_DIFF: predict_diff_byte(t);
      default: ;
    endcase
    push_outcome(crc_pkg::FAULT_NONE, '0, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus building blocks
  // ---------------------------------------------------------------------------

  // Every field random; callers overwrite what matters
  function automatic txn_t any_txn(input logic [1:0] op);
    txn_t t;
    t.operation     = op;
    t.first_cluster = $urandom;
    t.run_length    = crc_pkg::CLUS_W'($urandom_range(0, LENGTH_MAX));
    t.fault_kind    = 1'($urandom_range(0, 1));
    t.byte_index    = crc_pkg::BIDX_W'($urandom_range(0, crc_pkg::MAP_BYTES - 1));
    t.alloc_byte    = 8'($urandom_range(0, 255));
    return t;
  endfunction

  function automatic txn_t mark_txn(input logic [31:0] first,
                                    input logic [crc_pkg::CLUS_W-1:0] len,
                                    input logic kind);
    txn_t t;
    t = any_txn(crc_pkg::OP_MARK);
    t.first_cluster = first;
    t.run_length    = len;
    t.fault_kind    = kind;
    return t;
  endfunction

  function automatic txn_t diff_txn(input logic [crc_pkg::BIDX_W-1:0] index,
                                    input logic [7:0] alloc);
    txn_t t;
    t = any_txn(crc_pkg::OP_DIFF);
    t.byte_index = index;
    t.alloc_byte = alloc;
    return t;
  endfunction

  // Mostly in-volume runs and bytes, with some noise and stray clears
  function automatic txn_t random_txn(input int unsigned span);
    txn_t        t;
    int unsigned pick;
    int unsigned top_byte;
    pick     = $urandom_range(0, 99);
    top_byte = (span + 7) / 8;
    if (top_byte > crc_pkg::MAP_BYTES - 1) top_byte = crc_pkg::MAP_BYTES - 1;
    if (pick < 40) begin
      t = any_txn(crc_pkg::OP_MARK);
      t.first_cluster = $urandom_range(crc_pkg::FIRST_HEAP, span + crc_pkg::FIRST_HEAP);
      // long runs only where the volume keeps them short
      if (span > 1000 || $urandom_range(0, 7) != 0) begin
        t.run_length = crc_pkg::CLUS_W'($urandom_range(1, 12));
      end
    end else if (pick < 80) begin
      t = any_txn(crc_pkg::OP_DIFF);
      t.byte_index = crc_pkg::BIDX_W'($urandom_range(0, top_byte));
    end else if (pick < 82) begin
      t = any_txn(crc_pkg::OP_CLEAR);
    end else if (pick < 88) begin
      t = any_txn(OP_UNDEFINED);
    end else if (pick < 94) begin
      t = any_txn(crc_pkg::OP_MARK);
    end else begin
      t = any_txn(crc_pkg::OP_DIFF);
    end
    return t;
  endfunction

  // Offers one transaction, in bursts with random gaps unless flooding
  task automatic send_txn(input txn_t t);
    int unsigned gap;
    if (!flood && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        item_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    item_bus.valid         <= 1'b1;
    item_bus.operation     <= t.operation;
    item_bus.first_cluster <= t.first_cluster;
    item_bus.run_length    <= t.run_length;
    item_bus.fault_kind    <= t.fault_kind;
    item_bus.byte_index    <= t.byte_index;
    item_bus.alloc_byte    <= t.alloc_byte;
    do @(posedge clk); while (item_bus.ready !== 1'b1);
    predict_transaction(t);
    txns_sent++;
  endtask

  // Stop offering and let every awaited result come back
  task automatic wait_quiet();
    item_bus.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_cluster_count(input logic [crc_pkg::CLUS_W-1:0] value);
    wait_quiet();
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en      <= 1'b0;
    cluster_count_cfg  = value;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty volume: runs mark nothing, bytes are fully masked
  task automatic test_zero_volume();
    write_cluster_count('0);
    send_txn(mark_txn(32'd2, 17'd5, 1'b0));
    send_txn(diff_txn('0, 8'hFF));
    send_txn(any_txn(OP_UNDEFINED));
  endtask

  // Ten clusters: every run refusal, tail masking and the full fault burst
  task automatic test_small_volume();
    write_cluster_count(17'd10);
    send_txn(mark_txn(32'd2, 17'd4, 1'b0));
    send_txn(mark_txn(32'd4, 17'd3, 1'b1));            // already visited
    send_txn(mark_txn(32'd0, 17'd2, 1'b0));            // below the heap
    send_txn(mark_txn(32'd10, 17'd5, 1'b1));           // runs off the end
    send_txn(mark_txn(32'hFFFF_FFFF, 17'd4, 1'b0));    // wraps round
    send_txn(mark_txn(32'd6, 17'd0, 1'b1));            // empty run
    send_txn(mark_txn(32'd2, 17'h1FFFF, 1'b1));        // clamped length
    send_txn(diff_txn(13'd0, 8'h0F));
    send_txn(diff_txn(13'd0, 8'hF0));                  // eight faults
    send_txn(diff_txn(13'd1, 8'hFF));                  // tail masked
    send_txn(diff_txn(13'd1000, 8'hFF));               // beyond the volume
    send_txn(diff_txn(13'h1FFF, 8'hAA));
    send_txn(any_txn(OP_UNDEFINED));
    send_txn(any_txn(crc_pkg::OP_CLEAR));
    send_txn(diff_txn(13'd0, 8'hFF));
  endtask

  // Largest volume, marked end to end in one run
  task automatic test_full_volume();
    write_cluster_count(17'd65536);
    send_txn(any_txn(crc_pkg::OP_CLEAR));
    send_txn(mark_txn(32'd2, 17'd65536, 1'b0));
    send_txn(mark_txn(32'd2, 17'h1FFFF, 1'b1));
    send_txn(mark_txn(32'd65538, 17'd1, 1'b1));
    send_txn(diff_txn(13'h1FFF, 8'hFF));
  endtask

  // Back-to-back full fault bursts with the output open; relies on the fully marked map
  task automatic test_streaming_diff();
    int unsigned b;
    flood = 1'b1;
    for (b = 0; b < 8; b++) send_txn(diff_txn(crc_pkg::BIDX_W'(b), 8'h00));
    send_txn(any_txn(crc_pkg::OP_CLEAR));
    for (b = 0; b < 8; b++) send_txn(diff_txn(crc_pkg::BIDX_W'(b), 8'hFF));
    flood = 1'b0;
  endtask

  // Random traffic over several volume sizes, with one long output stall
  task automatic test_random_traffic();
    int unsigned spans [6];
    int unsigned p;
    int unsigned i;
    spans = '{1, 8, 37, 200, 1000, 131071};
    for (p = 0; p < 6; p++) begin
      write_cluster_count(crc_pkg::CLUS_W'(spans[p]));
      send_txn(any_txn(crc_pkg::OP_CLEAR));
      for (i = 0; i < 31; i++) begin
        if (p == 3 && i == 4) holdoff_left = 600;
        send_txn(random_txn(volume_span()));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Output ready: stretches of differing styles, plus requested hold-offs
  initial begin : result_pacing
    int unsigned stretch;
    int unsigned tick;
    pace_t       style;
    result_bus.ready <= 1'b0;
    stretch = 0;
    tick    = 0;
    style   = PACE_OPEN;
    forever begin
      @(posedge clk);
      tick++;
      if (holdoff_left != 0) begin
        holdoff_left--;
        result_bus.ready <= 1'b0;
      end else if (flood) begin
        result_bus.ready <= 1'b1;
      end else begin
        if (stretch == 0) begin
          stretch = $urandom_range(8, 80);
          style   = pace_t'($urandom_range(0, 3));
        end
        stretch--;
        case (style)
          PACE_OPEN:   result_bus.ready <= 1'b1;
          PACE_COIN:   result_bus.ready <= 1'($urandom_range(0, 1));
          PACE_SPARSE: result_bus.ready <= ($urandom_range(0, 3) == 0);
          default:     result_bus.ready <= (tick % 5) < 3;   // repeating rhythm, on more than off
        endcase
      end
    end
  end

  function automatic void flag_result(input string why, input outcome_t want);
    if (mismatches < REPORT_LIMIT) begin
      $display("[%0t] %s", $realtime, why);
      $display("  expected fault %0d cluster %0d last %0b used %0d lost %0d unset %0d",
               want.fault, want.cluster, want.last, want.used, want.lost, want.unset);
      $display("  actual   fault %0d cluster %0d last %0b used %0d lost %0d unset %0d",
               result_bus.fault, result_bus.fault_cluster, result_bus.last,
               result_bus.used_total, result_bus.lost_total, result_bus.mismatch_total);
    end
    mismatches++;
  endfunction

  // Each accepted result against the oldest prediction
  initial begin : result_check
    outcome_t want;
    outcome_t blank;
    forever begin
      @(posedge clk);
      if (!rst && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
        results_seen++;
        if (result_bus.fault <= crc_pkg::FAULT_UNSET) fault_hits[result_bus.fault]++;
        if (awaited_results.size() == 0) begin
          flag_result("result with nothing awaited", blank);
        end else begin
          want = awaited_results.pop_front();
          if (result_bus.fault !== want.fault || result_bus.fault_cluster !== want.cluster ||
              result_bus.last !== want.last || result_bus.used_total !== want.used ||
              result_bus.lost_total !== want.lost ||
              result_bus.mismatch_total !== want.unset) begin
            flag_result("result differs from prediction", want);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst                    <= 1'b1;
    cfg_write_en           <= 1'b0;
    cfg_write_data         <= '0;
    item_bus.valid         <= 1'b0;
    item_bus.operation     <= '0;
    item_bus.first_cluster <= '0;
    item_bus.run_length    <= '0;
    item_bus.fault_kind    <= 1'b0;
    item_bus.byte_index    <= '0;
    item_bus.alloc_byte    <= '0;
    visited_bits      = '0;
    used_tally        = '0;
    lost_tally        = '0;
    mismatch_tally    = '0;
    cluster_count_cfg = '0;
    flood             = 1'b0;
    burst_left        = 0;
    holdoff_left      = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_zero_volume();
    test_small_volume();
    test_full_volume();
    test_streaming_diff();
    test_random_traffic();

    wait_quiet();
    repeat (64) @(posedge clk);
    $display("Covered %0d transactions over volumes from empty to full size, %0d results checked.",
             txns_sent, results_seen);
    $display("Faults: %0d bad entry, %0d bad chain, %0d lost, %0d unset.",
             fault_hits[crc_pkg::FAULT_BAD_DIR], fault_hits[crc_pkg::FAULT_BAD_CHAIN],
             fault_hits[crc_pkg::FAULT_LOST], fault_hits[crc_pkg::FAULT_UNSET]);
    if (mismatches == 0 && awaited_results.size() == 0) begin
      $display("cluster_reference_checker regression: pass");
    end else begin
      $display("cluster_reference_checker regression: fail");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run
  initial begin : watchdog
    #40_000_000;
    $display("cluster_reference_checker regression: fail");
    $finish;
  end

endmodule
